/* sv/id3_pkg.sv */
// Shared types and constants for the ID3v2 text frame extractor.
package id3_pkg;

  // Reset value of the wanted frame id: "TIT2"
  localparam logic [31:0] FRAME_ID_RESET = 32'h5449_5432;

  // Header layout: ten bytes per header, last byte index nine
  localparam logic [3:0]  HDR_LAST_POS  = 4'd9;
  localparam logic [3:0]  HDR_DATA_POS  = 4'd8;
  localparam logic [3:0]  MAGIC_LEN     = 4'd3;
  localparam int unsigned HDR_BYTES     = 10;

  // Text encoding byte codes
  localparam logic [7:0] ENC_LATIN1 = 8'd0;
  localparam logic [7:0] ENC_UTF16  = 8'd1;
  localparam logic [7:0] ENC_UTF8   = 8'd3;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_FHDR = 3'd1,
    PH_SKIP = 3'd2,
    PH_ENC  = 3'd3,
    PH_TEXT = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NO_TAG    = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_BAD_ENC   = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  // Sub-state of the text body (also marks end of single-byte text)
  typedef enum logic [1:0] {
    TX_BOM0 = 2'd0,
    TX_SKIP = 2'd1,
    TX_LOW  = 2'd2,
    TX_END  = 2'd3
  } text_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] text_char;
    logic       done_res;
    logic [2:0] status;
  } out_t;

  // Result of one parse step
  typedef struct packed {
    logic has;
    out_t item;
  } res_t;

  // Bytes of the "ID3" tag magic
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0:    r = 8'h49;
      2'd1:    r = 8'h44;
      default: r = 8'h33;
    endcase
    return r;
  endfunction

endpackage

/* sv/id3_in_stage.sv */
// Input register stage: holds one transferred byte until the parser takes it.
module id3_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  id3_pkg::in_t    in_data_i,
  input  logic            take_i,
  output logic            item_valid_o,
  output id3_pkg::in_t    item_o
);

  logic         valid_q, valid_d;
  id3_pkg::in_t data_q;
  logic         load;

  // Accept whenever the held item leaves this cycle or the stage is empty
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

/* sv/id3_parse.sv */
// Tag and frame parser: per-byte state update and result generation.
module id3_parse #(
  parameter int unsigned MaxFrameBytes = 1048576
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          en_i,
  input  id3_pkg::in_t  item_i,
  output id3_pkg::res_t res_o
);

  localparam int unsigned FlW = $clog2(MaxFrameBytes + 1);
  localparam logic [31:0] MaxSize = 32'(MaxFrameBytes);
  localparam logic [27:0] MinTag  = 28'(id3_pkg::HDR_BYTES);
  localparam logic [28:0] HdrLen  = 29'(id3_pkg::HDR_BYTES);

  logic [31:0]       frame_id_q;
  id3_pkg::phase_e   phase_q, phase_d;
  logic [3:0]        bpos_q, bpos_d;
  logic [27:0]       tag_left_q, tag_left_d;
  logic [63:0]       hdr_q, hdr_d;
  logic [FlW-1:0]    frame_left_q, frame_left_d;
  logic              utf16_q, utf16_d;
  id3_pkg::text_e    tx_q, tx_d;
  logic              finished_q, finished_d;

  logic [7:0]        b;
  logic              cv, done;
  logic [7:0]        ch;
  id3_pkg::status_e  st;
  logic [31:0]       fsize;
  logic [31:0]       fid;
  logic [28:0]       used;
  logic [27:0]       tag_after;
  logic [FlW-1:0]    fl_dec;
  logic [27:0]       h_size;

  assign b      = item_i.data_byte;
  assign fsize  = hdr_q[31:0];
  assign fid    = hdr_q[63:32];
  assign fl_dec = (frame_left_q != '0) ? frame_left_q - FlW'(1) : frame_left_q;
  assign used   = HdrLen + {1'b0, fsize[27:0]};
  assign tag_after = ({1'b0, tag_left_q} > used) ? 28'({1'b0, tag_left_q} - used) : '0;
  // Syncsafe size from the last three held bytes and the byte now arriving
  assign h_size = {hdr_q[22:16], hdr_q[14:8], hdr_q[6:0], b[6:0]};

  // Work out next state and the result for the byte at the input register
  always_comb begin
    phase_d      = phase_q;
    bpos_d       = bpos_q;
    tag_left_d   = tag_left_q;
    hdr_d        = hdr_q;
    frame_left_d = frame_left_q;
    utf16_d      = utf16_q;
    tx_d         = tx_q;
    finished_d   = finished_q;
    cv           = 1'b0;
    ch           = '0;
    done         = 1'b0;
    st           = id3_pkg::ST_FOUND;

    if (!finished_q) begin
      unique case (phase_q)
        id3_pkg::PH_TAG: begin
          hdr_d = {hdr_q[55:0], b};
          if (bpos_q < id3_pkg::MAGIC_LEN && b != id3_pkg::magic_byte(bpos_q[1:0])) begin
            done = 1'b1;
            st   = id3_pkg::ST_NO_TAG;
          end else if (bpos_q == id3_pkg::HDR_LAST_POS) begin
            tag_left_d = h_size;
            bpos_d     = '0;
            phase_d    = id3_pkg::PH_FHDR;
            if (h_size < MinTag) begin
              done = 1'b1;
              st   = id3_pkg::ST_ABSENT;
            end
          end else begin
            bpos_d = bpos_q + 4'd1;
          end
        end
        id3_pkg::PH_FHDR: begin
          if (bpos_q < id3_pkg::HDR_DATA_POS) begin
            hdr_d = {hdr_q[55:0], b};
          end
          if (bpos_q == id3_pkg::HDR_LAST_POS) begin
            bpos_d = '0;
            if (fid[31:24] == 8'd0 || fsize > {4'd0, tag_left_q} || fsize > MaxSize) begin
              done = 1'b1;
              st   = id3_pkg::ST_ABSENT;
            end else begin
              tag_left_d   = tag_after;
              frame_left_d = fsize[FlW-1:0];
              if (fid == frame_id_q && fsize > 32'd1) begin
                phase_d = id3_pkg::PH_ENC;
              end else if (fsize != 32'd0) begin
                phase_d = id3_pkg::PH_SKIP;
              end else if (tag_after < MinTag) begin
                done = 1'b1;
                st   = id3_pkg::ST_ABSENT;
              end
            end
          end else begin
            bpos_d = bpos_q + 4'd1;
          end
        end
        id3_pkg::PH_SKIP: begin
          frame_left_d = fl_dec;
          if (fl_dec == '0) begin
            phase_d = id3_pkg::PH_FHDR;
            bpos_d  = '0;
            if (tag_left_q < MinTag) begin
              done = 1'b1;
              st   = id3_pkg::ST_ABSENT;
            end
          end
        end
        id3_pkg::PH_ENC: begin
          if (b == id3_pkg::ENC_LATIN1 || b == id3_pkg::ENC_UTF8) begin
            utf16_d = 1'b0;
            tx_d    = id3_pkg::TX_BOM0;
            phase_d = id3_pkg::PH_TEXT;
          end else if (b == id3_pkg::ENC_UTF16 && frame_left_q >= FlW'(3)) begin
            utf16_d = 1'b1;
            tx_d    = id3_pkg::TX_BOM0;
            phase_d = id3_pkg::PH_TEXT;
          end else begin
            done = 1'b1;
            st   = id3_pkg::ST_BAD_ENC;
          end
          frame_left_d = fl_dec;
        end
        id3_pkg::PH_TEXT: begin
          if (!utf16_q) begin
            if (tx_q != id3_pkg::TX_END) begin
              if (b == 8'd0) begin
                tx_d = id3_pkg::TX_END;
              end else begin
                cv = 1'b1;
                ch = b;
              end
            end
          end else begin
            unique case (tx_q)
              id3_pkg::TX_BOM0: tx_d = id3_pkg::TX_SKIP;
              id3_pkg::TX_SKIP: tx_d = id3_pkg::TX_LOW;
              id3_pkg::TX_LOW: begin
                tx_d = id3_pkg::TX_SKIP;
                if (frame_left_q >= FlW'(2)) begin
                  if (b == 8'd0) begin
                    tx_d = id3_pkg::TX_END;
                  end else if (b < id3_pkg::ASCII_LIMIT) begin
                    cv = 1'b1;
                    ch = b;
                  end
                end
              end
              default: tx_d = tx_q;
            endcase
          end
          frame_left_d = fl_dec;
          if (fl_dec == '0) begin
            done = 1'b1;
            st   = id3_pkg::ST_FOUND;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      if (done) begin
        finished_d = 1'b1;
      end
    end

    // Close the file early on its final byte
    if (item_i.end_of_file && !finished_d) begin
      done = 1'b1;
      priority if (phase_d == id3_pkg::PH_TAG) begin
        st = id3_pkg::ST_NO_TAG;
      end else if (phase_d == id3_pkg::PH_ENC || phase_d == id3_pkg::PH_TEXT) begin
        st = id3_pkg::ST_TRUNCATED;
      end else begin
        st = id3_pkg::ST_ABSENT;
      end
    end

    // Drop all file state at end of file
    if (item_i.end_of_file) begin
      phase_d      = id3_pkg::PH_TAG;
      bpos_d       = '0;
      tag_left_d   = '0;
      hdr_d        = '0;
      frame_left_d = '0;
      utf16_d      = 1'b0;
      tx_d         = id3_pkg::TX_BOM0;
      finished_d   = 1'b0;
    end
  end

  always_comb begin
    res_o.has             = cv || done;
    res_o.item.char_valid = cv;
    res_o.item.text_char  = ch;
    res_o.item.done_res   = done;
    res_o.item.status     = done ? st : id3_pkg::ST_FOUND;
  end

  // Hold the wanted frame id
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q <= id3_pkg::FRAME_ID_RESET;
    end else if (cfg_we_i) begin
      frame_id_q <= cfg_data_i;
    end
  end

  // Advance the parse state on each byte taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= id3_pkg::PH_TAG;
      bpos_q       <= '0;
      tag_left_q   <= '0;
      hdr_q        <= '0;
      frame_left_q <= '0;
      utf16_q      <= 1'b0;
      tx_q         <= id3_pkg::TX_BOM0;
      finished_q   <= 1'b0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      bpos_q       <= bpos_d;
      tag_left_q   <= tag_left_d;
      hdr_q        <= hdr_d;
      frame_left_q <= frame_left_d;
      utf16_q      <= utf16_d;
      tx_q         <= tx_d;
      finished_q   <= finished_d;
    end
  end

  a_status_only_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.has && !res_o.item.done_res) |-> res_o.item.status == id3_pkg::ST_FOUND)
    else $error("status set on a result without done");

  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.item.char_valid |-> res_o.item.text_char != 8'd0)
    else $error("zero byte sent as a character");

  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!finished_q && (phase_q == id3_pkg::PH_ENC || phase_q == id3_pkg::PH_TEXT))
    |-> frame_left_q != '0)
    else $error("wanted frame body active with no bytes left");

  a_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bpos_q <= id3_pkg::HDR_LAST_POS)
    else $error("header byte counter past last byte");

endmodule

/* sv/id3_out_stage.sv */
// Output result register with valid/stall handshake.
module id3_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  id3_pkg::res_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output id3_pkg::out_t out_data_o
);

  logic          valid_q, valid_d;
  id3_pkg::out_t data_q;

  // Room for a new result when empty or the held one transfers now
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_i.has;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.has) begin
      data_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* sv/id3v2_text_frame_extract.sv */
// Top level: ID3v2 tag walker that extracts the text of one chosen frame.
// Throughput: one byte per cycle while out_stall_i is low; each byte passes the
// input register, one pass of the parser logic, and the result register; bytes
// with no result leave no output.
// Reset (rst_ni low, asynchronous) empties both registers, sets the frame id to
// "TIT2" and returns the parser to the tag header; end_of_file does the same
// for the parser state only.
module id3v2_text_frame_extract #(
  parameter int unsigned MAX_FRAME_BYTES = 1048576
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  id3_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output id3_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_data_i
);

  logic          item_valid;
  id3_pkg::in_t  item;
  logic          out_free;
  logic          take;
  id3_pkg::res_t res;

  // Parse the held byte whenever the result register has room
  assign take = item_valid && out_free;

  id3_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  id3_parse #(
    .MaxFrameBytes (MAX_FRAME_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .en_i       (take),
    .item_i     (item),
    .res_o      (res)
  );

  id3_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
